// ----- src/assert_macros.svh -----
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- src/lupa_pkg.sv -----
// Package with types and constants of the least-used port allocator.
`timescale 1ns / 1ps
`default_nettype none
package lupa_pkg;
  localparam int unsigned PORT_COUNT   = 65536;
  localparam int unsigned DYNAMIC_BASE = 32768;
  localparam logic [31:0] MAX_LISTED   = 32'd65535;
  // Entry word: use, out use, address, port, in_map, stamp.
  localparam int unsigned ENTRY_W      = 32 + 32 + 32 + 16 + 1 + 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_USE_UF  = 2'd1;
  localparam logic [1:0] ST_OUT_UF  = 2'd2;

  localparam logic [1:0] KIND_MAP    = 2'd0;
  localparam logic [1:0] KIND_PREF   = 2'd1;
  localparam logic [1:0] KIND_LEAST  = 2'd2;
  localparam logic [1:0] KIND_DIRECT = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] port_number;
    logic [31:0] lan_address;
    logic [15:0] local_port;
    logic        outgoing;
  } in_item_t;

  typedef struct packed {
    logic [15:0] chosen_port;
    logic [1:0]  status;
    logic [1:0]  choice_kind;
  } out_item_t;

  typedef struct packed {
    logic [31:0] use_cnt;
    logic [31:0] out_cnt;
    logic [31:0] addr;
    logic [15:0] lport;
    logic        in_map;
    logic [31:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

// ----- src/lupa_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module lupa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- src/lupa_cmp.sv -----
// Shared compare unit: judges one scanned entry against the request and the best so far.
`timescale 1ns / 1ps
`default_nettype none
module lupa_cmp (
  input  wire lupa_pkg::entry_t e,
  input  wire logic [31:0]      lan_address,
  input  wire logic [15:0]      local_port,
  input  wire logic             have,
  input  wire logic [31:0]      best_cnt,
  input  wire logic [31:0]      best_stamp,
  output logic                  pair_eq,
  output logic                  map_hit,
  output logic                  better
);
  always_comb begin
    pair_eq = (e.addr == lan_address) && (e.lport == local_port);
    map_hit = e.in_map && pair_eq;
    better  = (e.use_cnt <= lupa_pkg::MAX_LISTED) &&
              (!have || (e.use_cnt < best_cnt) ||
               ((e.use_cnt == best_cnt) && (e.stamp < best_stamp)));
  end
endmodule
`default_nettype wire

// ----- src/least_used_port_allocator.sv -----
// Top level of the least-used port allocator: sequencer, entry memory and result register.
//
//  channel | direction | payload    | handshake
//  in      | input     | in_item_t  | in_valid / in_stall
//  out     | output    | out_item_t | out_valid / out_stall
//
// After reset a clearing pass writes all 65536 entries, one a cycle; no item is taken meanwhile.
// Allocate and deallocate pass through read, wait, update and result after acceptance.
// A get scans the 32768 dynamic entries through one memory port and one compare unit,
// one entry a cycle, then reads the preferred port and reads and updates the chosen one.
// The next item is taken while a result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module least_used_port_allocator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lupa_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lupa_pkg::out_item_t     out_data
);
`include "assert_macros.svh"
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_LAST  = 4'd3;
  localparam logic [3:0] S_PREQ  = 4'd4;
  localparam logic [3:0] S_PWAIT = 4'd5;
  localparam logic [3:0] S_PDEC  = 4'd6;
  localparam logic [3:0] S_TREAD = 4'd7;
  localparam logic [3:0] S_TWAIT = 4'd8;
  localparam logic [3:0] S_UPD   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  lupa_pkg::in_item_t req_r, req_nxt;
  logic [15:0] best_r, best_nxt;
  logic [31:0] bcnt_r, bcnt_nxt, bstamp_r, bstamp_nxt;
  logic        have_r, have_nxt, found_r, found_nxt;
  logic [15:0] chosen_r, chosen_nxt;
  logic [1:0]  kind_r, kind_nxt, status_r, status_nxt;
  logic        take_r, take_nxt, outg_r, outg_nxt;
  logic [31:0] stampc_r, stampc_nxt;
  lupa_pkg::out_item_t res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic        we;
  logic [15:0] addr;
  lupa_pkg::entry_t wentry, rentry;
  logic        pair_eq, map_hit, better;

  lupa_ram #(.WIDTH(lupa_pkg::ENTRY_W), .DEPTH(lupa_pkg::PORT_COUNT)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wentry), .rdata(rentry)
  );

  lupa_cmp u_cmp (
    .e(rentry), .lan_address(req_r.lan_address), .local_port(req_r.local_port),
    .have(have_r), .best_cnt(bcnt_r), .best_stamp(bstamp_r),
    .pair_eq(pair_eq), .map_hit(map_hit), .better(better)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;

  logic accept;
  assign accept = in_valid && !in_stall;

  always_comb begin
    lupa_pkg::entry_t e;
    logic was_bound, avail, restamp;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    req_nxt    = req_r;
    best_nxt   = best_r;
    bcnt_nxt   = bcnt_r;
    bstamp_nxt = bstamp_r;
    have_nxt   = have_r;
    found_nxt  = found_r;
    chosen_nxt = chosen_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    take_nxt   = take_r;
    outg_nxt   = outg_r;
    stampc_nxt = stampc_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && out_stall;
    we         = 1'b0;
    addr       = chosen_r;
    wentry     = '0;
    e          = rentry;
    was_bound  = (rentry.addr != '0) || (rentry.lport != '0);
    avail      = chosen_r >= 16'(lupa_pkg::DYNAMIC_BASE);
    restamp    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        we           = 1'b1;
        addr         = cnt_r[15:0];
        wentry.stamp = {16'd0, cnt_r[15:0]};
        cnt_nxt      = cnt_r + 17'd1;
        if (cnt_r[15:0] == 16'hFFFF) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt    = in_data;
          chosen_nxt = in_data.port_number;
          status_nxt = lupa_pkg::ST_OK;
          kind_nxt   = lupa_pkg::KIND_DIRECT;
          have_nxt   = 1'b0;
          found_nxt  = 1'b0;
          best_nxt   = '0;
          outg_nxt   = in_data.outgoing;
          take_nxt   = (in_data.op == lupa_pkg::OP_ALLOC);
          cnt_nxt    = 17'(lupa_pkg::DYNAMIC_BASE);
          priority if (in_data.op == lupa_pkg::OP_GET) begin
            outg_nxt  = 1'b1;
            take_nxt  = 1'b1;
            state_nxt = S_SCAN;
          end else if (in_data.op == lupa_pkg::OP_ALLOC || in_data.op == lupa_pkg::OP_FREE)
          begin
            state_nxt = S_TREAD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN, S_LAST: begin
        // Address cnt_r is issued now; data of cnt_r-1 arrives when past the base.
        addr = cnt_r[15:0];
        if (cnt_r != 17'(lupa_pkg::DYNAMIC_BASE) || state_r == S_LAST) begin
          if (map_hit && !found_r) begin
            found_nxt  = 1'b1;
            chosen_nxt = 16'(cnt_r - 17'd1);
          end
          if (better) begin
            have_nxt   = 1'b1;
            best_nxt   = 16'(cnt_r - 17'd1);
            bcnt_nxt   = rentry.use_cnt;
            bstamp_nxt = rentry.stamp;
          end
        end
        cnt_nxt = cnt_r + 17'd1;
        if (state_r == S_LAST) begin
          state_nxt = S_PREQ;
        end else if (cnt_r == 17'(lupa_pkg::PORT_COUNT - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_PREQ: begin
        addr      = req_r.port_number;
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        addr      = req_r.port_number;
        state_nxt = S_PDEC;
      end
      S_PDEC: begin
        priority if (found_r) begin
          kind_nxt = lupa_pkg::KIND_MAP;
        end else if (req_r.port_number >= 16'(lupa_pkg::DYNAMIC_BASE) &&
                     (rentry.use_cnt == '0 || pair_eq)) begin
          kind_nxt   = lupa_pkg::KIND_PREF;
          chosen_nxt = req_r.port_number;
        end else begin
          kind_nxt   = lupa_pkg::KIND_LEAST;
          chosen_nxt = have_r ? best_r : '0;
        end
        state_nxt = S_TREAD;
      end
      S_TREAD: begin
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (take_r) begin
          if (rentry.use_cnt == '0) begin
            e.addr  = req_r.lan_address;
            e.lport = req_r.local_port;
            if (!was_bound && (req_r.lan_address != '0 || req_r.local_port != '0)) begin
              e.in_map = 1'b1;
            end
          end else if (!pair_eq) begin
            if (was_bound) begin
              e.in_map = 1'b0;
            end
            e.addr  = '0;
            e.lport = '0;
          end
          e.use_cnt = rentry.use_cnt + 32'd1;
          if (outg_r) begin
            e.out_cnt = rentry.out_cnt + 32'd1;
          end
          restamp = 1'b1;
        end else if (rentry.use_cnt == '0) begin
          status_nxt = lupa_pkg::ST_USE_UF;
        end else if (outg_r && rentry.out_cnt == '0) begin
          status_nxt = lupa_pkg::ST_OUT_UF;
        end else begin
          e.use_cnt = rentry.use_cnt - 32'd1;
          if (outg_r) begin
            e.out_cnt = rentry.out_cnt - 32'd1;
          end
          if (e.use_cnt == '0 && was_bound) begin
            e.in_map = 1'b0;
          end
          restamp = 1'b1;
        end
        if (restamp && avail && e.use_cnt <= lupa_pkg::MAX_LISTED) begin
          e.stamp    = stampc_r;
          stampc_nxt = stampc_r + 32'd1;
        end
        wentry    = e;
        we        = restamp;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || !out_stall) begin
          res_nxt.chosen_port = chosen_r;
          res_nxt.status      = status_r;
          res_nxt.choice_kind = kind_r;
          ovalid_nxt          = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          ovalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      cnt_r    <= '0;
      stampc_r <= 32'(lupa_pkg::PORT_COUNT);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      stampc_r <= stampc_nxt;
      ovalid_r <= ovalid_nxt;
    end
    req_r    <= req_nxt;
    best_r   <= best_nxt;
    bcnt_r   <= bcnt_nxt;
    bstamp_r <= bstamp_nxt;
    have_r   <= have_nxt;
    found_r  <= found_nxt;
    chosen_r <= chosen_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    take_r   <= take_nxt;
    outg_r   <= outg_nxt;
    res_r    <= res_nxt;
  end

  `AST_IMPLY(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, in_stall, "item taken while busy")
  `AST_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != S_IDLE, "accept did not start work")
  `AST_IMPLY(a_write_only_upd, clk, rst_n, we && state_r != S_CLEAR, state_r == S_UPD,
    "entry written outside update")
endmodule
`default_nettype wire
